FILE: rtl/core/io_ports_with_psg_strobe_unit_assert.svh
// ----------------------------------------------------------------------------
// io_ports_with_psg_strobe_unit_assert.svh
// assertion macros used by the checker file of the i/o window
// ----------------------------------------------------------------------------
`ifndef IO_PORTS_WITH_PSG_STROBE_UNIT_ASSERT_SVH
`define IO_PORTS_WITH_PSG_STROBE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define IOPSG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("iopsg assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define IOPSG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("iopsg assertion failed");

`endif

FILE: rtl/core/iopsg_pkg.sv
// ----------------------------------------------------------------------------
// iopsg_pkg
// types and constants of the i/o window with sound chip strobes
// ----------------------------------------------------------------------------
`default_nettype none

package iopsg_pkg;

	// configuration register index
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_BANK_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_BANK_B = 2'd1;

	// switch reset values
	localparam logic [7:0] SWITCH_BANK_A_RESET = 8'hdf;
	localparam logic [3:0] SWITCH_BANK_B_RESET = 4'hf;

	// access kind
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	// window addresses
	localparam logic [15:0] ADDR_PORT_0 = 16'h3800;	// p1 read, control write
	localparam logic [15:0] ADDR_PORT_1 = 16'h3801;	// p2 read, sound latch write
	localparam logic [15:0] ADDR_PORT_2 = 16'h3802;	// switch bank a
	localparam logic [15:0] ADDR_PORT_3 = 16'h3803;	// switch bank b + system

	// control byte bits
	localparam int CTL_FLIP_BIT   = 0;
	localparam int CTL_CHIP0_SEL  = 4;
	localparam int CTL_CHIP0_WR   = 5;
	localparam int CTL_CHIP1_SEL  = 6;
	localparam int CTL_CHIP1_WR   = 7;

	typedef struct packed {
		logic        req_type;
		logic [15:0] bus_address;
		logic [7:0]  write_byte;
		logic [7:0]  player_one_port;
		logic [7:0]  player_two_port;
		logic [7:0]  system_port;
		logic        in_vblank;
	} iopsg_req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       chip0_strobe;
		logic       chip0_port;
		logic       chip1_strobe;
		logic       chip1_port;
		logic [7:0] sound_byte;
		logic       flip_out;
	} iopsg_rsp_t;

	typedef struct packed {
		logic [7:0] switch_bank_a;
		logic [3:0] switch_bank_b;
	} iopsg_cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/io_ports_with_psg_strobe_unit.sv
// ----------------------------------------------------------------------------
// io_ports_with_psg_strobe_unit
// cpu i/o window at 0x3800-0x3803 with sound chip write strobes
// ----------------------------------------------------------------------------
// Each bus access is one beat on the in channel and gives exactly one beat on
// the out channel. The block takes one beat per clock while in_ready is high:
// a beat is captured in the input register, decoded combinationally and moves
// into the result register once that register is empty or drained. Window
// state (control byte, sound latch, flip bit) updates as the beat moves into
// the result register, so back to back accesses see each other in order.
// The input register can still take a beat while a result waits on out_ready;
// in_ready drops only when both registers are full and the output is stalled.
// Switch banks are written through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module io_ports_with_psg_strobe_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  iopsg_pkg::iopsg_req_t            in_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	output iopsg_pkg::iopsg_rsp_t            out_data,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [iopsg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [7:0]                        cfg_data
);
	import iopsg_pkg::*;

	iopsg_cfg_t cfg;
	iopsg_req_t req_s1;
	logic       vld_s1;
	iopsg_rsp_t rsp_comb;
	iopsg_rsp_t rsp_s2;
	logic       vld_s2;
	logic       advance;
	logic       commit;

	assign cfg_ready = 1'b1;

	iopsg_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// pipeline flow control
	assign advance  = !vld_s2 || out_ready;
	assign commit   = vld_s1 && advance;
	assign in_ready = !vld_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
	end

	iopsg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_comb)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_s2 <= rsp_comb;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = rsp_s2;

endmodule

`default_nettype wire

FILE: rtl/core/iopsg_cfg_regs.sv
// ----------------------------------------------------------------------------
// iopsg_cfg_regs
// dip switch registers written through the configuration channel
// ----------------------------------------------------------------------------
`default_nettype none

module iopsg_cfg_regs (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              wr_en,
	input  wire [iopsg_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire [7:0]                        wr_data,
	output iopsg_pkg::iopsg_cfg_t            cfg
);
	import iopsg_pkg::*;

	logic [7:0] switch_bank_a_q;
	logic [3:0] switch_bank_b_q;

	// register write, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_bank_a_q <= SWITCH_BANK_A_RESET;
			switch_bank_b_q <= SWITCH_BANK_B_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SWITCH_BANK_A: switch_bank_a_q <= wr_data;
				CFG_SWITCH_BANK_B: switch_bank_b_q <= wr_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg.switch_bank_a = switch_bank_a_q;
	assign cfg.switch_bank_b = switch_bank_b_q;

endmodule

`default_nettype wire

FILE: rtl/core/iopsg_core.sv
// ----------------------------------------------------------------------------
// iopsg_core
// address decode, read mux, control edge detect and window state
// ----------------------------------------------------------------------------
`default_nettype none

module iopsg_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    commit,
	input  iopsg_pkg::iopsg_req_t  req,
	input  iopsg_pkg::iopsg_cfg_t  cfg,
	output iopsg_pkg::iopsg_rsp_t  rsp
);
	import iopsg_pkg::*;

	logic [7:0] prev_ctl_q;
	logic [7:0] sound_latch_q;
	logic       flip_q;

	logic       is_write;
	logic       ctl_wr;
	logic       latch_wr;
	logic       edge0;
	logic       edge1;
	logic [7:0] rd_mux;

	// read data select
	always_comb begin
		case (req.bus_address)
			ADDR_PORT_0: rd_mux = req.player_one_port;
			ADDR_PORT_1: rd_mux = {req.in_vblank, req.player_two_port[6:0]};
			ADDR_PORT_2: rd_mux = cfg.switch_bank_a;
			ADDR_PORT_3: rd_mux = {req.system_port[7:4], cfg.switch_bank_b};
			default:     rd_mux = 8'h00;
		endcase
	end

	// write decode and falling edge detect on the control byte
	assign is_write = (req.req_type == REQ_WRITE);
	assign ctl_wr   = is_write && (req.bus_address == ADDR_PORT_0);
	assign latch_wr = is_write && (req.bus_address == ADDR_PORT_1);
	assign edge0    = ctl_wr && prev_ctl_q[CTL_CHIP0_WR] && !req.write_byte[CTL_CHIP0_WR];
	assign edge1    = ctl_wr && prev_ctl_q[CTL_CHIP1_WR] && !req.write_byte[CTL_CHIP1_WR];

	// result beat
	assign rsp.read_byte    = is_write ? 8'h00 : rd_mux;
	assign rsp.chip0_strobe = edge0;
	assign rsp.chip0_port   = edge0 && !prev_ctl_q[CTL_CHIP0_SEL];
	assign rsp.chip1_strobe = edge1;
	assign rsp.chip1_port   = edge1 && !prev_ctl_q[CTL_CHIP1_SEL];
	assign rsp.sound_byte   = (edge0 || edge1) ? sound_latch_q : 8'h00;
	assign rsp.flip_out     = ctl_wr ? req.write_byte[CTL_FLIP_BIT] : flip_q;

	// state update when the beat moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ctl_q    <= 8'h00;
			sound_latch_q <= 8'h00;
			flip_q        <= 1'b0;
		end else if (commit) begin
			if (ctl_wr) begin
				prev_ctl_q <= req.write_byte;
				flip_q     <= req.write_byte[CTL_FLIP_BIT];
			end
			if (latch_wr) begin
				sound_latch_q <= req.write_byte;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/io_ports_with_psg_strobe_unit_checker.sv
// ----------------------------------------------------------------------------
// io_ports_with_psg_strobe_unit_checker
// port-level checks of the i/o window, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "io_ports_with_psg_strobe_unit_assert.svh"

module io_ports_with_psg_strobe_unit_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_ready,
	input  wire                              out_valid,
	input  wire                              out_ready,
	input  iopsg_pkg::iopsg_rsp_t            out_data
);
	import iopsg_pkg::*;

	// a stalled result beat holds
	`IOPSG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

	// the input side only backs up behind a stalled output
	`IOPSG_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready)

	// read data and sound strobes never share a beat
	`IOPSG_ASSERT_NOW(a_read_no_strobe, out_valid && (out_data.read_byte != 8'h00),
		!out_data.chip0_strobe && !out_data.chip1_strobe)

	// without a strobe the port selects and sound byte stay clear
	`IOPSG_ASSERT_NOW(a_idle_sound, out_valid && !out_data.chip0_strobe && !out_data.chip1_strobe,
		!out_data.chip0_port && !out_data.chip1_port && (out_data.sound_byte == 8'h00))

endmodule

bind io_ports_with_psg_strobe_unit io_ports_with_psg_strobe_unit_checker u_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// i/o window with sound chip strobes: reads, control writes and latch writes
// ----------------------------------------------------------------------------
// A directed run covers the read ports, the ignored writes and strobes from
// both chips together and from each chip alone. Random runs under several
// switch settings then follow, with idle cycles on both channels in all but
// one, and one long output stall. Each input beat is predicted by the
// scoreboard and each output beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;
	import iopsg_pkg::*;

	localparam int CYCLE_LIMIT     = 100000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int IDLE_PCT        = 23;
	localparam int PRINT_CAP       = 40;

	// cfg indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

	// predicts the window state and holds the outstanding result beats
	class window_scoreboard;
		logic [7:0] bank_a;
		logic [3:0] bank_b;
		logic [7:0] control_byte;
		logic [7:0] sound_latch;
		logic       flip;
		iopsg_rsp_t pending_rsp[$];
		int         errors;

		function new();
			bank_a       = SWITCH_BANK_A_RESET;
			bank_b       = SWITCH_BANK_B_RESET;
			control_byte = '0;
			sound_latch  = '0;
			flip         = 1'b0;
			errors       = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
			if (idx == CFG_SWITCH_BANK_A)
				bank_a = value;
			else if (idx == CFG_SWITCH_BANK_B)
				bank_b = value[3:0];
		endfunction

		// work out the result of one accepted bus access
		function void note_access(iopsg_req_t acc);
			iopsg_rsp_t r;
			r = '0;
			if (acc.req_type == REQ_READ) begin
				case (acc.bus_address)
					ADDR_PORT_0: r.read_byte = acc.player_one_port;
					ADDR_PORT_1: r.read_byte = {acc.in_vblank, acc.player_two_port[6:0]};
					ADDR_PORT_2: r.read_byte = bank_a;
					ADDR_PORT_3: r.read_byte = {acc.system_port[7:4], bank_b};
					default:     r.read_byte = '0;
				endcase
			end else if (acc.bus_address == ADDR_PORT_0) begin
				flip = acc.write_byte[CTL_FLIP_BIT];
				// falling edges against the previous control byte
				if (control_byte[CTL_CHIP0_WR] && !acc.write_byte[CTL_CHIP0_WR]) begin
					r.chip0_strobe = 1'b1;
					r.chip0_port   = !control_byte[CTL_CHIP0_SEL];
					r.sound_byte   = sound_latch;
				end
				if (control_byte[CTL_CHIP1_WR] && !acc.write_byte[CTL_CHIP1_WR]) begin
					r.chip1_strobe = 1'b1;
					r.chip1_port   = !control_byte[CTL_CHIP1_SEL];
					r.sound_byte   = sound_latch;
				end
				control_byte = acc.write_byte;
			end else if (acc.bus_address == ADDR_PORT_1) begin
				sound_latch = acc.write_byte;
			end
			r.flip_out = flip;
			pending_rsp.push_back(r);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("mismatch %0d at %0t: %s", errors, $realtime, msg);
		endtask

		// compare one output beat with the oldest prediction
		task check_result(iopsg_rsp_t got);
			iopsg_rsp_t want;
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("result beat %h with nothing pending", got));
				return;
			end
			want = pending_rsp.pop_front();
			if (got.read_byte !== want.read_byte)
				report_mismatch($sformatf("read_byte %h, want %h", got.read_byte, want.read_byte));
			if (got.chip0_strobe !== want.chip0_strobe)
				report_mismatch($sformatf("chip0_strobe %b, want %b",
					got.chip0_strobe, want.chip0_strobe));
			if (got.chip0_port !== want.chip0_port)
				report_mismatch($sformatf("chip0_port %b, want %b", got.chip0_port, want.chip0_port));
			if (got.chip1_strobe !== want.chip1_strobe)
				report_mismatch($sformatf("chip1_strobe %b, want %b",
					got.chip1_strobe, want.chip1_strobe));
			if (got.chip1_port !== want.chip1_port)
				report_mismatch($sformatf("chip1_port %b, want %b", got.chip1_port, want.chip1_port));
			if (got.sound_byte !== want.sound_byte)
				report_mismatch($sformatf("sound_byte %h, want %h", got.sound_byte, want.sound_byte));
			if (got.flip_out !== want.flip_out)
				report_mismatch($sformatf("flip_out %b, want %b", got.flip_out, want.flip_out));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	iopsg_req_t           in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	iopsg_rsp_t           out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data  = '0;

	bit               idle_on       = 1'b1;
	bit               hold_off_req  = 1'b0;
	int               cycle_count   = 0;
	window_scoreboard board         = new();

	io_ports_with_psg_strobe_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// input beat monitor
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_access(in_data);
	end

	// output beat monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
	end

	// output side: random idling, plus one long hold-off on request
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				stall_left = HOLD_OFF_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	function automatic iopsg_req_t bus_access(logic kind, logic [15:0] addr, logic [7:0] wdata,
			logic [7:0] p1, logic [7:0] p2, logic [7:0] sys, logic vb);
		iopsg_req_t acc;
		acc.req_type        = kind;
		acc.bus_address     = addr;
		acc.write_byte      = wdata;
		acc.player_one_port = p1;
		acc.player_two_port = p2;
		acc.system_port     = sys;
		acc.in_vblank       = vb;
		return acc;
	endfunction

	// offer one beat and hold it until taken; valid stays high for the next beat
	task automatic send_access(input iopsg_req_t acc);
		if (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (idle_on && $urandom_range(99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		in_data  <= acc;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.write_register(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drop valid and wait for every pending result beat
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending_rsp.size() != 0)
			@(posedge clk);
	endtask

	// random accesses, mostly to the control and latch ports inside the window
	task automatic run_random(input int count);
		iopsg_req_t acc;
		int         roll;
		for (int i = 0; i < count; i++) begin
			acc.req_type        = 1'($urandom_range(1));
			acc.write_byte      = 8'($urandom_range(255));
			acc.player_one_port = 8'($urandom_range(255));
			acc.player_two_port = 8'($urandom_range(255));
			acc.system_port     = 8'($urandom_range(255));
			acc.in_vblank       = 1'($urandom_range(1));
			roll = int'($urandom_range(99));
			if (roll < 40)
				acc.bus_address = ADDR_PORT_0;
			else if (roll < 65)
				acc.bus_address = ADDR_PORT_1;
			else if (roll < 75)
				acc.bus_address = ADDR_PORT_2;
			else if (roll < 82)
				acc.bus_address = ADDR_PORT_3;
			else if (roll < 91)
				acc.bus_address = ADDR_PORT_0 ^ (16'h1 << $urandom_range(15));
			else
				acc.bus_address = 16'($urandom_range(16'hffff));
			send_access(acc);
		end
	endtask

	// main sequence
	initial begin : main_seq
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read ports under reset switch values, then out-of-window reads
		send_access(bus_access(REQ_READ, ADDR_PORT_0, 8'h00, 8'h00, 8'hff, 8'hff, 1'b0));
		send_access(bus_access(REQ_READ, ADDR_PORT_0, 8'hff, 8'hff, 8'h00, 8'h00, 1'b1));
		send_access(bus_access(REQ_READ, ADDR_PORT_1, 8'h00, 8'h00, 8'hff, 8'h00, 1'b0));
		send_access(bus_access(REQ_READ, ADDR_PORT_1, 8'h00, 8'hff, 8'h00, 8'hff, 1'b1));
		send_access(bus_access(REQ_READ, ADDR_PORT_2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_READ, ADDR_PORT_3, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1));
		send_access(bus_access(REQ_READ, ADDR_PORT_3, 8'h00, 8'hff, 8'hff, 8'h0f, 1'b0));
		send_access(bus_access(REQ_READ, 16'h0000, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
		send_access(bus_access(REQ_READ, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));

		// latch, then rising edges only, then both chips fall with address ports
		send_access(bus_access(REQ_WRITE, ADDR_PORT_1, 8'ha5, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		// both chips fall with data ports
		send_access(bus_access(REQ_WRITE, ADDR_PORT_1, 8'h3c, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'ha0, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		// chip 0 alone, address port, flip set
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'h30, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0));
		// chip 1 alone, address port
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'hc0, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'h41, 8'h00, 8'h00, 8'h00, 1'b0));
		// writes that change nothing
		send_access(bus_access(REQ_WRITE, ADDR_PORT_2, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1));
		send_access(bus_access(REQ_WRITE, ADDR_PORT_3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_WRITE, 16'hffff, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
		send_access(bus_access(REQ_WRITE, 16'h0000, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0));
		// latch set to all ones with a read in between, then a chip 1 edge to show it
		send_access(bus_access(REQ_WRITE, ADDR_PORT_1, 8'hff, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_READ, ADDR_PORT_1, 8'h00, 8'h12, 8'h34, 8'h56, 1'b1));
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'h80, 8'h00, 8'h00, 8'h00, 1'b0));
		send_access(bus_access(REQ_WRITE, ADDR_PORT_0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
		wait_idle();

		// switch extremes, upper nibble of bank b dropped, unused index
		write_cfg(CFG_SWITCH_BANK_A, 8'h00);
		write_cfg(CFG_SWITCH_BANK_B, 8'hf0);
		write_cfg(CFG_UNUSED_2, 8'hff);
		run_random(110);
		wait_idle();

		// other extremes, no idling on either side
		write_cfg(CFG_SWITCH_BANK_A, 8'hff);
		write_cfg(CFG_SWITCH_BANK_B, 8'h0f);
		write_cfg(CFG_UNUSED_3, 8'h00);
		idle_on = 1'b0;
		run_random(110);
		wait_idle();
		idle_on = 1'b1;

		// random switches, long output stall partway through
		write_cfg(CFG_SWITCH_BANK_A, 8'($urandom_range(255)));
		write_cfg(CFG_SWITCH_BANK_B, 8'($urandom_range(255)));
		run_random(40);
		hold_off_req = 1'b1;
		run_random(80);
		wait_idle();

		write_cfg(CFG_SWITCH_BANK_B, 8'($urandom_range(255)));
		write_cfg(CFG_SWITCH_BANK_A, 8'($urandom_range(255)));
		run_random(110);
		wait_idle();

		// catch stray result beats
		repeat (8) @(posedge clk);
		if (board.errors == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/iopsg_pkg.sv
rtl/core/iopsg_cfg_regs.sv
rtl/core/iopsg_core.sv
rtl/core/io_ports_with_psg_strobe_unit.sv
rtl/core/io_ports_with_psg_strobe_unit_checker.sv
dv/testbench.sv
